// ----- src/assert_macros.svh -----
// Assertion helpers shared by the tracker modules.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define TKST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tkst: assertion failed");

// Same check with a caller-supplied message.
`define TKST_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

// ----- src/tkst_pkg.sv -----
package tkst_pkg;

  // top_count register
  localparam int KW = 7;

  // command codes (in_tuser)
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // event codes (out_tuser)
  localparam int EV_W = 2;
  localparam logic [EV_W-1:0] EV_ENTER  = 2'd0;
  localparam logic [EV_W-1:0] EV_LEAVE  = 2'd1;
  localparam logic [EV_W-1:0] EV_REJECT = 2'd2;

  // shift command broadcast to every cell
  typedef struct packed {
    logic do_ins;
    logic do_rem;
  } shift_ctl_t;

  // event queue load
  typedef struct packed {
    logic first;
    logic second;
  } evq_push_t;

endpackage

// ----- src/tkst_cell.sv -----
// One slot of the sorted store. Compares its entry with the broadcast key
// and, on a shift, takes the key or a neighbor's entry.
module tkst_cell import tkst_pkg::*; #(
  parameter int SCORE_WIDTH = 32,
  parameter int ID_WIDTH    = 16
) (
  input  logic                   clk,
  input  shift_ctl_t             ctl,
  input  logic                   occ,
  input  logic [SCORE_WIDTH-1:0] key_score,
  input  logic [ID_WIDTH-1:0]    key_id,
  input  logic [SCORE_WIDTH-1:0] left_score,
  input  logic [ID_WIDTH-1:0]    left_id,
  input  logic                   left_above,
  input  logic [SCORE_WIDTH-1:0] right_score,
  input  logic [ID_WIDTH-1:0]    right_id,
  output logic [SCORE_WIDTH-1:0] score,
  output logic [ID_WIDTH-1:0]    id,
  output logic                   above,
  output logic                   hit
);

  logic [SCORE_WIDTH-1:0] score_r, score_nxt;
  logic [ID_WIDTH-1:0]    id_r, id_nxt;
  logic                   gt, eq;

  assign eq    = (score_r == key_score) && (id_r == key_id);
  assign gt    = (score_r != key_score) ? (score_r > key_score) : (id_r > key_id);
  assign above = occ && gt;
  // first slot not above the key that also matches it
  assign hit   = occ && eq && left_above;

  always_comb begin
    score_nxt = score_r;
    id_nxt    = id_r;
    if (ctl.do_ins) begin
      if (left_above && !above) begin
        score_nxt = key_score;
        id_nxt    = key_id;
      end else if (!left_above) begin
        score_nxt = left_score;
        id_nxt    = left_id;
      end
    end else if (ctl.do_rem && !above) begin
      score_nxt = right_score;
      id_nxt    = right_id;
    end
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
    id_r    <= id_nxt;
  end

  assign score = score_r;
  assign id    = id_r;

endmodule

// ----- src/tkst_evq.sv -----
`include "assert_macros.svh"

// Two-word result buffer. Loaded with one or two words only when empty,
// drained one word per handshake.
module tkst_evq import tkst_pkg::*; #(
  parameter int W = 51
) (
  input  logic         clk,
  input  logic         rst_n,
  input  evq_push_t    push,
  input  logic [W-1:0] wd0,
  input  logic [W-1:0] wd1,
  output logic         empty,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic [W-1:0] slot0_r, slot1_r;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         pop;

  assign pop       = (cnt_r != 2'd0) && out_ready;
  assign empty     = (cnt_r == 2'd0);
  assign out_valid = !empty;
  assign out_data  = slot0_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push.first) begin
      cnt_nxt = push.second ? 2'd2 : 2'd1;
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      slot0_r <= wd0;
      slot1_r <= wd1;
    end else if (pop) begin
      slot0_r <= slot1_r;
    end
  end

  `TKST_ASSERT(a_second_needs_first, push.second |-> push.first)
  `TKST_ASSERT_MSG(a_load_when_empty, push.first |-> cnt_r == 2'd0, "tkst: load into busy queue")
  `TKST_ASSERT(a_cnt_range, cnt_r != 2'd3)

endmodule

// ----- src/topk_sorted_store_tracker_core.sv -----
// Streaming top-k tracker over a sorted store of distinct (score, id) items.
// Input words (in_*): in_tuser is the command (add / remove), in_tdata the
// item. Each word yields zero, one or two result words on out_*: an item
// entering the top k, an item leaving it, or an add rejected because the
// store is full. out_tlast marks the final result word of an input word.
// Adding a present item or removing an absent one yields nothing.
// cfg_wr_en / cfg_wr_data write k (top_count); 0 acts as 1. Write only
// while the block is idle; it takes effect on the next command.
// Flow: a word is taken into the item register; then, once the output
// buffer is empty, all cells compare with it in parallel and shift while
// the results are loaded into the 2-word output buffer. A word is taken
// only while the block is idle, so a new word waits until the last one
// has executed; execution waits until the output buffer has drained.
// Reset clears the fill count, the output buffer and sets k to 1; cell
// contents are left as they are. A stalled receiver holds the buffer; one
// further input word is still taken into the item register meanwhile.
`include "assert_macros.svh"

module topk_sorted_store_tracker_core import tkst_pkg::*; #(
  parameter int CAPACITY    = 64,
  parameter int SCORE_WIDTH = 32,
  parameter int ID_WIDTH    = 16
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  // in_tdata: score, item_id, zero pad
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  input  logic [((SCORE_WIDTH+ID_WIDTH+7)/8)*8-1:0]     in_tdata,
  input  logic                                          in_tuser,  // cmd
  // out_tdata: event_score, event_id, zero pad
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  output logic [((SCORE_WIDTH+ID_WIDTH+7)/8)*8-1:0]     out_tdata,
  output logic [EV_W-1:0]                               out_tuser, // event_res
  output logic                                          out_tlast,
  input  logic                                          cfg_wr_en,
  input  logic [KW-1:0]                                 cfg_wr_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int TW = (CW > KW + 1) ? CW : KW + 1;
  localparam int EW = SCORE_WIDTH + ID_WIDTH;
  localparam int DW = ((EW + 7) / 8) * 8;
  localparam int QW = 1 + EV_W + EW;   // {last, res, id, score}

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                 state_r, state_nxt;
  logic [KW-1:0]          top_count_r;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   cmd_r;
  logic [SCORE_WIDTH-1:0] key_score_r;
  logic [ID_WIDTH-1:0]    key_id_r;

  logic [SCORE_WIDTH-1:0] c_score [CAPACITY];
  logic [ID_WIDTH-1:0]    c_id    [CAPACITY];
  logic [CAPACITY-1:0]    above, hit, occ, sel_bit, km1_bit;

  logic [KW-1:0]          k_eff;
  logic [TW-1:0]          km1, tgt, cnt_ext;
  logic [SCORE_WIDTH-1:0] rank_score;
  logic [ID_WIDTH-1:0]    rank_id;
  logic                   present, full, in_top, q_empty, fire, in_fire;
  shift_ctl_t             ctl;
  evq_push_t              push;
  logic [QW-1:0]          wd0, wd1, head;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign k_eff   = (top_count_r == '0) ? KW'(1) : top_count_r;
  assign km1     = TW'(k_eff) - TW'(1);
  assign tgt     = (cmd_r == CMD_ADD) ? km1 : TW'(k_eff);
  assign cnt_ext = TW'(count_r);

  // ---- cell chain ----
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    localparam logic [TW-1:0] IDX = TW'(gi);
    assign occ[gi]     = IDX < cnt_ext;
    assign sel_bit[gi] = (IDX == tgt);
    assign km1_bit[gi] = (IDX == km1);

    if (gi == 0) begin : g_head
      tkst_cell #(.SCORE_WIDTH(SCORE_WIDTH), .ID_WIDTH(ID_WIDTH)) u_cell (
        .clk(clk), .ctl(ctl), .occ(occ[gi]),
        .key_score(key_score_r), .key_id(key_id_r),
        .left_score(key_score_r), .left_id(key_id_r), .left_above(1'b1),
        .right_score(c_score[(gi+1) % CAPACITY]), .right_id(c_id[(gi+1) % CAPACITY]),
        .score(c_score[gi]), .id(c_id[gi]), .above(above[gi]), .hit(hit[gi])
      );
    end else if (gi == CAPACITY - 1) begin : g_tail
      tkst_cell #(.SCORE_WIDTH(SCORE_WIDTH), .ID_WIDTH(ID_WIDTH)) u_cell (
        .clk(clk), .ctl(ctl), .occ(occ[gi]),
        .key_score(key_score_r), .key_id(key_id_r),
        .left_score(c_score[gi-1]), .left_id(c_id[gi-1]), .left_above(above[gi-1]),
        .right_score(c_score[gi]), .right_id(c_id[gi]),
        .score(c_score[gi]), .id(c_id[gi]), .above(above[gi]), .hit(hit[gi])
      );
    end else begin : g_mid
      tkst_cell #(.SCORE_WIDTH(SCORE_WIDTH), .ID_WIDTH(ID_WIDTH)) u_cell (
        .clk(clk), .ctl(ctl), .occ(occ[gi]),
        .key_score(key_score_r), .key_id(key_id_r),
        .left_score(c_score[gi-1]), .left_id(c_id[gi-1]), .left_above(above[gi-1]),
        .right_score(c_score[gi+1]), .right_id(c_id[gi+1]),
        .score(c_score[gi]), .id(c_id[gi]), .above(above[gi]), .hit(hit[gi])
      );
    end
  end

  // Result bus: the cell at the boundary rank drives the displaced or
  // promoted entry (rank k-1 for add, rank k for remove, before the shift).
  always_comb begin
    rank_score = '0;
    rank_id    = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (sel_bit[i]) begin
        rank_score = rank_score | c_score[i];
        rank_id    = rank_id | c_id[i];
      end
    end
  end

  assign present = |hit;
  assign full    = (count_r == CW'(CAPACITY));
  // insert/remove position is inside the top k unless rank k-1 ranks above
  assign in_top  = !(|(km1_bit & above));
  assign fire    = (state_r == S_EXEC) && q_empty;

  // ---- command decode ----
  always_comb begin
    ctl       = '0;
    push      = '0;
    count_nxt = count_r;
    wd0       = {1'b1, EV_ENTER, key_id_r, key_score_r};
    wd1       = {1'b1, EV_LEAVE, rank_id, rank_score};
    if (fire) begin
      if (cmd_r == CMD_ADD) begin
        if (!present) begin
          if (full) begin
            push.first = 1'b1;
            wd0        = {1'b1, EV_REJECT, key_id_r, key_score_r};
          end else begin
            ctl.do_ins = 1'b1;
            count_nxt  = count_r + CW'(1);
            if (in_top) begin
              push.first = 1'b1;
              // an entry is pushed past rank k-1
              if (cnt_ext >= TW'(k_eff)) begin
                push.second = 1'b1;
                wd0         = {1'b0, EV_ENTER, key_id_r, key_score_r};
              end
            end
          end
        end
      end else if (present) begin
        ctl.do_rem = 1'b1;
        count_nxt  = count_r - CW'(1);
        if (in_top) begin
          push.first = 1'b1;
          wd0        = {1'b1, EV_LEAVE, key_id_r, key_score_r};
          // an entry moves up into rank k-1
          if (cnt_ext > TW'(k_eff)) begin
            push.second = 1'b1;
            wd0         = {1'b0, EV_LEAVE, key_id_r, key_score_r};
            wd1         = {1'b1, EV_ENTER, rank_id, rank_score};
          end
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_EXEC;
      S_EXEC:  if (fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      top_count_r <= KW'(1);
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_wr_en) begin
        top_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r       <= in_tuser;
      key_score_r <= in_tdata[SCORE_WIDTH-1:0];
      key_id_r    <= in_tdata[EW-1:SCORE_WIDTH];
    end
  end

  tkst_evq #(.W(QW)) u_evq (
    .clk(clk), .rst_n(rst_n), .push(push), .wd0(wd0), .wd1(wd1),
    .empty(q_empty), .out_valid(out_tvalid), .out_ready(out_tready), .out_data(head)
  );

  assign out_tdata = DW'(head[EW-1:0]);
  assign out_tuser = head[EW+EV_W-1:EW];
  assign out_tlast = head[QW-1];

  `TKST_ASSERT_MSG(a_single_match, $onehot0(hit), "tkst: item stored twice")
  `TKST_ASSERT(a_one_shift, !(ctl.do_ins && ctl.do_rem))
  `TKST_ASSERT(a_ins_grows, ctl.do_ins |=> count_r == $past(count_r) + CW'(1))
  `TKST_ASSERT(a_count_bound, count_r <= CW'(CAPACITY))

endmodule

// ----- test/tb_topk_sorted_store_tracker_core.sv -----
`timescale 1ns / 1ps
module tb_topk_sorted_store_tracker_core import tkst_pkg::*; ();

  localparam int CAP         = 64;
  localparam int SW          = 32;
  localparam int IW          = 16;
  localparam int DW          = ((SW + IW + 7) / 8) * 8;
  localparam int SETTLE      = 8;        // cycles past the last result before touching k
  localparam int PHASE_WORDS = 88;
  localparam int TIMEOUT_NS  = 2_000_000;

  // one result word as seen on out_*
  typedef struct packed {
    logic [EV_W-1:0] res;
    logic [SW-1:0]   score;
    logic [IW-1:0]   id;
    logic            last;
  } result_word_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  // stimulus table row; typed clear means the tracker model supplies the results
  typedef struct packed {
    row_kind_t     kind;
    logic          cmd;
    logic [SW-1:0] score;
    logic [IW-1:0] id;
    logic [KW-1:0] k;
    logic          typed;
    logic [1:0]    n_typed;
    result_word_t  ev0;
    result_word_t  ev1;
  } stim_row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [DW-1:0] in_tdata = '0;      // score, item_id
  logic          in_tuser = 1'b0;    // cmd
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [DW-1:0] out_tdata;          // event_score, event_id
  logic [EV_W-1:0] out_tuser;        // event_res
  logic          out_tlast;
  logic          cfg_wr_en = 1'b0;
  logic [KW-1:0] cfg_wr_data = '0;

  // no random idling on either side while set
  bit calm = 1'b0;

  // tracker model state: sorted store, fill level, k
  logic [SW-1:0] rank_score [CAP];
  logic [IW-1:0] rank_id [CAP];
  int            rank_fill = 0;
  logic [KW-1:0] top_k = KW'(1);

  // results of the latest word, then the queue of results still owed by the block
  result_word_t  step_ev [2];
  int            step_n;
  result_word_t  pending_events [$];
  int            mismatches = 0;

  stim_row_t     directed_rows [$];

  always #2 clk = ~clk;

  topk_sorted_store_tracker_core #(
    .CAPACITY    (CAP),
    .SCORE_WIDTH (SW),
    .ID_WIDTH    (IW)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Model of one accepted word. Finds the rank p of the item, applies the
  // add or remove, and lists the enter / leave / reject words it causes.
  function automatic void track_step(input logic cmd, input logic [SW-1:0] s,
                                     input logic [IW-1:0] id);
    int p;
    int k;
    bit present;
    step_n = 0;
    k = (top_k == 0) ? 1 : int'(top_k);   // zero k acts as one
    p = 0;
    while (p < rank_fill &&
           (rank_score[p] > s || (rank_score[p] == s && rank_id[p] > id)))
      p++;
    present = (p < rank_fill) && rank_score[p] == s && rank_id[p] == id;
    if (cmd == CMD_ADD) begin
      if (present)
        return;                          // duplicate add: silent
      if (rank_fill >= CAP) begin
        step_ev[0] = {EV_REJECT, s, id, 1'b1};
        step_n = 1;
        return;
      end
      for (int i = rank_fill; i > p; i--) begin
        rank_score[i] = rank_score[i-1];
        rank_id[i]    = rank_id[i-1];
      end
      rank_score[p] = s;
      rank_id[p]    = id;
      rank_fill++;
      if (p < k) begin
        step_ev[0] = {EV_ENTER, s, id, 1'b0};
        step_n = 1;
        // item pushed down to rank k drops out of the chosen set
        if (rank_fill > k) begin
          step_ev[1] = {EV_LEAVE, rank_score[k], rank_id[k], 1'b0};
          step_n = 2;
        end
      end
    end else begin
      if (!present)
        return;                          // absent remove: silent
      for (int i = p; i + 1 < rank_fill; i++) begin
        rank_score[i] = rank_score[i+1];
        rank_id[i]    = rank_id[i+1];
      end
      rank_fill--;
      if (p < k) begin
        step_ev[0] = {EV_LEAVE, s, id, 1'b0};
        step_n = 1;
        // the item now at rank k-1 moves up into the chosen set
        if (rank_fill >= k) begin
          step_ev[1] = {EV_ENTER, rank_score[k-1], rank_id[k-1], 1'b0};
          step_n = 2;
        end
      end
    end
    if (step_n > 0)
      step_ev[step_n-1].last = 1'b1;
  endfunction

  function automatic stim_row_t word_row(input logic cmd, input logic [SW-1:0] s,
                                         input logic [IW-1:0] id, input int n_typed = -1,
                                         input result_word_t e0 = '0,
                                         input result_word_t e1 = '0);
    stim_row_t r;
    r = '0;
    r.kind  = ROW_WORD;
    r.cmd   = cmd;
    r.score = s;
    r.id    = id;
    if (n_typed >= 0) begin
      r.typed   = 1'b1;
      r.n_typed = n_typed[1:0];
      r.ev0     = e0;
      r.ev1     = e1;
    end
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [KW-1:0] k);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.k    = k;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input result_word_t want,
                                 input result_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t ns %s: want res=%0d score=%h id=%h last=%b, got res=%0d score=%h id=%h last=%b",
               $realtime, what, want.res, want.score, want.id, want.last,
               got.res, got.score, got.id, got.last);
  endtask

  // Drive one input word, hold it until taken, then record what it owes.
  // Called right after a rising edge; leaves in_tvalid high so a following
  // word goes out back to back.
  task automatic send_word(input stim_row_t row);
    while (!calm && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= row.cmd;
    in_tdata  <= {row.id, row.score};
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    track_step(row.cmd, row.score, row.id);
    if (row.typed) begin
      if (row.n_typed > 0) pending_events.push_back(row.ev0);
      if (row.n_typed > 1) pending_events.push_back(row.ev1);
    end else begin
      for (int i = 0; i < step_n; i++)
        pending_events.push_back(step_ev[i]);
    end
  endtask

  // Stop sending, wait for every owed result, then let a silent word finish.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_events.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_top_count(input logic [KW-1:0] v);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    top_k = v;
  endtask

  // Result side: check each taken word against the oldest owed result, then
  // pick the ready level for the next edge.
  always @(posedge clk) begin : result_check
    result_word_t got;
    result_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[SW-1:0], out_tdata[SW+IW-1:SW], out_tlast};
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_events.pop_front();
        if (got.res !== want.res || got.score !== want.score ||
            got.id !== want.id || got.last !== want.last)
          report_mismatch("result mismatch", want, got);
      end
    end
    out_tready <= calm || ($urandom_range(99) >= 6);
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [KW-1:0] phase_k [9];
    stim_row_t r;
    int pick;
    int j;
    int hi;
    int k_eff;
    int add_pct;

    // k settings per random phase: extremes, zero, above capacity, a few between
    phase_k = '{7'd1, 7'd64, 7'd0, 7'd3, 7'd127, 7'd8, 7'd2, 7'd17, 7'd40};

    // Directed table. Starts at the reset k of one; typed rows are plain
    // enough to write down, the rest go through the model.
    directed_rows.push_back(word_row(CMD_ADD, 32'd5, 16'h0010, 1,
                                     {EV_ENTER, 32'd5, 16'h0010, 1'b1}));
    directed_rows.push_back(word_row(CMD_ADD, 32'd5, 16'h0010, 0));        // duplicate
    directed_rows.push_back(word_row(CMD_REMOVE, 32'd7, 16'h0007, 0));     // absent
    directed_rows.push_back(word_row(CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF, 2,
                                     {EV_ENTER, 32'hFFFF_FFFF, 16'hFFFF, 1'b0},
                                     {EV_LEAVE, 32'd5, 16'h0010, 1'b1}));
    directed_rows.push_back(word_row(CMD_ADD, 32'd0, 16'h0000, 0));        // below top k
    directed_rows.push_back(word_row(CMD_ADD, 32'd5, 16'h0011));           // score tie
    directed_rows.push_back(word_row(CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 2,
                                     {EV_LEAVE, 32'hFFFF_FFFF, 16'hFFFF, 1'b0},
                                     {EV_ENTER, 32'd5, 16'h0011, 1'b1}));
    directed_rows.push_back(word_row(CMD_ADD, 32'd5, 16'h000F));
    directed_rows.push_back(word_row(CMD_REMOVE, 32'd0, 16'h0000));        // unchosen remove
    directed_rows.push_back(word_row(CMD_REMOVE, 32'd5, 16'h0011));
    directed_rows.push_back(cfg_row(7'd0));                                // zero k
    directed_rows.push_back(word_row(CMD_ADD, 32'd6, 16'h0001));
    directed_rows.push_back(cfg_row(7'd127));                              // k over fill
    directed_rows.push_back(word_row(CMD_ADD, 32'd0, 16'hFFFF));
    directed_rows.push_back(word_row(CMD_REMOVE, 32'd6, 16'h0001));
    directed_rows.push_back(word_row(CMD_ADD, 32'hFFFF_FFFF, 16'h0000));
    directed_rows.push_back(cfg_row(7'd2));
    directed_rows.push_back(word_row(CMD_ADD, 32'h8000_0000, 16'h8000));
    directed_rows.push_back(word_row(CMD_ADD, 32'hFFFF_FFFF, 16'h8000));
    directed_rows.push_back(word_row(CMD_REMOVE, 32'h8000_0000, 16'h8000));
    directed_rows.push_back(word_row(CMD_REMOVE, 32'hFFFF_FFFF, 16'h0000));
    directed_rows.push_back(word_row(CMD_REMOVE, 32'd0, 16'h0000, 0));     // gone already

    // synchronous reset, held for the repeat below
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        set_top_count(directed_rows[i].k);
      else
        send_word(directed_rows[i]);
    end

    // Random phases, one k each. Phase 1 (k = 64) is add heavy to fill the
    // store and hit the full-store reject; phase 3 runs with no idling.
    for (int ph = 0; ph < 9; ph++) begin
      set_top_count(phase_k[ph]);
      calm = (ph == 3);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        k_eff = (top_k == 0) ? 1 : int'(top_k);
        add_pct = (ph == 1) ? 85 : (rank_fill < 24 ? 60 : 45);
        r = word_row(CMD_ADD, $urandom(), 16'($urandom_range(65535)));
        pick = $urandom_range(99);
        if ($urandom_range(99) < add_pct) begin
          if (pick >= 70 && pick < 85 && rank_fill > 0) begin
            // same score as a stored item, fresh id: tie ordering
            j = $urandom_range(rank_fill - 1);
            r.score = rank_score[j];
          end else if (pick >= 85 && pick < 95) begin
            // tiny pool: many collisions and ties
            r.score = $urandom_range(7);
            r.id    = 16'($urandom_range(7));
          end else if (pick >= 95 && rank_fill > 0) begin
            j = $urandom_range(rank_fill - 1);
            r.score = rank_score[j];
            r.id    = rank_id[j];
          end
        end else begin
          r.cmd = CMD_REMOVE;
          if (rank_fill > 0 && pick < 80) begin
            // three eighths of the hits go to the chosen set
            hi = (k_eff < rank_fill) ? k_eff : rank_fill;
            j = (pick < 30) ? $urandom_range(hi - 1) : $urandom_range(rank_fill - 1);
            r.score = rank_score[j];
            r.id    = rank_id[j];
          end else if (rank_fill > 0 && pick < 90) begin
            // near miss: stored score, neighbor id
            j = $urandom_range(rank_fill - 1);
            r.score = rank_score[j];
            r.id    = rank_id[j] + 16'd1;
          end
        end
        send_word(r);
      end
    end

    drain_results();
    calm = 1'b0;
    repeat (4 * SETTLE) @(posedge clk);

    if (mismatches == 0 && pending_events.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
